[src/msspi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msspi_pkg: shared types and constants
// Sequencer states, status codes, register indexes and probe-unit handshake.
// ----------------------------------------------------------------------------
package msspi_pkg;

	localparam int SEP_W = 34;
	localparam int CNT_W = 13;
	localparam int IN_W  = 16;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_CLOSE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		REG_MIN_SEP = 1'b0,
		REG_TARGET  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_RD_MID,
		ST_CHK_MID,
		ST_DN_RD,
		ST_DN_WAIT,
		ST_UP_RD,
		ST_UP_WAIT,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS,
		ST_OUT
	} seq_state_t;

	// verdict of the shared distance unit
	typedef struct packed {
		logic valid;
		logic close;
		logic stop;
	} probe_res_t;

endpackage

[src/msspi_probe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msspi_probe: shared distance unit
// Squares the three coordinate differences, registers, then sums and compares.
// ----------------------------------------------------------------------------
module msspi_probe
	import msspi_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] cx,
	input  logic [COORD_BITS-1:0] cy,
	input  logic [COORD_BITS-1:0] cz,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COORD_BITS-1:0] pz,
	input  logic [SEP_W-1:0]      min_sep_sq,
	output probe_res_t            res
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] dx, dy, dz;
	logic [SQ_W-1:0]       sx_s1, sy_s1, sz_s1;
	logic                  vld_s1;
	logic [SQ_W+1:0]       sum_sq;
	logic [SEP_W:0]        lim2;

	// absolute differences
	assign dx = (cx >= px) ? cx - px : px - cx;
	assign dy = (cy >= py) ? cy - py : py - cy;
	assign dz = (cz >= pz) ? cz - pz : pz - cz;

	// squares, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= SQ_W'(dx) * SQ_W'(dx);
		sy_s1 <= SQ_W'(dy) * SQ_W'(dy);
		sz_s1 <= SQ_W'(dz) * SQ_W'(dz);
	end

	// sum and compare
	assign sum_sq = (SQ_W+2)'(sx_s1) + (SQ_W+2)'(sy_s1) + (SQ_W+2)'(sz_s1);
	assign lim2   = {min_sep_sq, 1'b0};

	always_comb begin
		res.valid = vld_s1;
		res.close = (SEP_W+SQ_W+2)'(sum_sq) <= (SEP_W+SQ_W+2)'(min_sep_sq);
		res.stop  = (SEP_W+SQ_W+2)'(sz_s1) > (SEP_W+SQ_W+2)'(lim2);
	end

endmodule

[src/min_separation_sorted_point_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_separation_sorted_point_insert: z-sorted hard-sphere point table
// Binary search on z, neighbor scan both ways, sorted insert by shifting.
// ----------------------------------------------------------------------------
// Search, scan and shift all share the table memory's single port.
// One transaction at a time; a new candidate is taken only while idle.
// Reset clears the count and restores configuration defaults; table entries are
// never read before written. Configuration writes are accepted in any cycle.
module min_separation_sorted_point_insert
	import msspi_pkg::*;
#(
	parameter int POINT_CAPACITY = 4096,
	parameter int COORD_BITS     = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  cand_x,
	input  logic [IN_W-1:0]  cand_y,
	input  logic [IN_W-1:0]  cand_z,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] insert_position,
	output logic [CNT_W-1:0] point_count,
	output logic             done_res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [SEP_W-1:0] cfg_data
);

	localparam int AW  = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
	localparam int NW  = $clog2(POINT_CAPACITY + 1);
	localparam int EW  = 3 * COORD_BITS;

	seq_state_t state_q, state_d;

	logic [SEP_W-1:0]      min_sep_q;
	logic [CNT_W-1:0]      target_q;
	logic [NW-1:0]         n_q;
	logic [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [NW-1:0]         lo_q, hi_q, k_q, pos_q;
	logic [1:0]            st_q;
	logic [EW-1:0]         mem [POINT_CAPACITY];
	logic [EW-1:0]         rd_q;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  rd_en, wr_en;
	logic [EW-1:0]         wr_data;
	logic [COORD_BITS-1:0] rz;
	logic                  probe_go;
	logic                  wait_q;
	probe_res_t            pr;
	logic [NW-1:0]         mid;
	logic [NW:0]           mid_sum;
	logic [NW-1:0]         n_last;

	assign rz      = rd_q[COORD_BITS-1:0];
	assign mid_sum = (NW+1)'(lo_q) + (NW+1)'(hi_q);
	assign mid     = mid_sum[NW:1];
	assign n_last  = n_q - NW'(1);

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q <= SEP_W'(65536);
			target_q  <= CNT_W'(4096);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_SEP: min_sep_q <= cfg_data;
				REG_TARGET:  target_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// table memory, one port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	msspi_probe #(.COORD_BITS(COORD_BITS)) u_probe (
		.clk(clk), .arst_n(arst_n), .start(probe_go),
		.cx(cx_q), .cy(cy_q), .cz(cz_q),
		.px(rd_q[3*COORD_BITS-1:2*COORD_BITS]),
		.py(rd_q[2*COORD_BITS-1:COORD_BITS]), .pz(rz),
		.min_sep_sq(min_sep_q), .res(pr)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (in_valid) begin
					if (n_q >= NW'(POINT_CAPACITY)) state_d = ST_OUT;
					else if (n_q == '0) state_d = ST_INS;
					else state_d = ST_RD_FIRST;
				end
			ST_RD_FIRST:  state_d = ST_CHK_FIRST;
			ST_CHK_FIRST: state_d = (cz_q <= rz) ? ST_DN_RD : ST_RD_LAST;
			ST_RD_LAST:   state_d = ST_CHK_LAST;
			ST_CHK_LAST:
				if (cz_q >= rz) state_d = ST_DN_RD;
				else if (n_last - lo_q > NW'(1)) state_d = ST_RD_MID;
				else state_d = ST_DN_RD;
			ST_RD_MID:    state_d = ST_CHK_MID;
			ST_CHK_MID:
				if (cz_q < rz) state_d = (mid - lo_q > NW'(1)) ? ST_RD_MID : ST_DN_RD;
				else state_d = (hi_q - mid > NW'(1)) ? ST_RD_MID : ST_DN_RD;
			ST_DN_RD:     state_d = ST_DN_WAIT;
			ST_DN_WAIT:
				if (pr.valid) begin
					if (pr.close) state_d = ST_OUT;
					else if (pr.stop || k_q == '0) state_d =
						(hi_q < n_q) ? ST_UP_RD : ST_SH_RD;
					else state_d = ST_DN_RD;
				end
			ST_UP_RD:     state_d = ST_UP_WAIT;
			ST_UP_WAIT:
				if (pr.valid) begin
					if (pr.close) state_d = ST_OUT;
					else if (pr.stop || k_q + NW'(1) >= n_q) state_d = ST_SH_RD;
					else state_d = ST_UP_RD;
				end
			ST_SH_RD:     state_d = (k_q > hi_q) ? ST_SH_WR : ST_INS;
			ST_SH_WR:     state_d = ST_SH_RD;
			ST_INS:       state_d = ST_OUT;
			ST_OUT:       if (out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory and probe controls
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = AW'(pos_q);
		wr_data  = {cx_q, cy_q, cz_q};
		probe_go = 1'b0;
		unique case (state_q)
			ST_RD_FIRST: begin rd_en = 1'b1; rd_addr = '0; end
			ST_RD_LAST:  begin rd_en = 1'b1; rd_addr = AW'(n_last); end
			ST_RD_MID:   begin rd_en = 1'b1; rd_addr = AW'(mid); end
			ST_DN_RD, ST_UP_RD: begin rd_en = 1'b1; rd_addr = AW'(k_q); end
			ST_DN_WAIT, ST_UP_WAIT: probe_go = 1'b0;
			ST_SH_RD:    begin rd_en = 1'b1; rd_addr = AW'(k_q - NW'(1)); end
			ST_SH_WR:    begin wr_en = 1'b1; wr_addr = AW'(k_q); wr_data = rd_q; end
			ST_INS:      begin wr_en = 1'b1; wr_addr = AW'(hi_q); end
			default: ;
		endcase
		// probe starts in the same cycle that the scan read data appears in rd_q
		if (state_q == ST_DN_WAIT || state_q == ST_UP_WAIT)
			probe_go = !wait_q;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DN_WAIT || state_q == ST_UP_WAIT) wait_q <= !pr.valid;
			else wait_q <= 1'b0;
			if (state_q == ST_INS) n_q <= n_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cx_q <= cand_x[COORD_BITS-1:0];
				cy_q <= cand_y[COORD_BITS-1:0];
				cz_q <= cand_z[COORD_BITS-1:0];
				hi_q <= '0;
				lo_q <= '0;
				st_q <= (n_q >= NW'(POINT_CAPACITY)) ? STATUS_FULL : STATUS_OK;
				k_q  <= '0;
			end
			ST_CHK_FIRST: if (cz_q <= rz) begin hi_q <= '0; k_q <= '0; end
			ST_CHK_LAST:
				if (cz_q >= rz) begin hi_q <= n_q; k_q <= n_last; end
				else begin hi_q <= n_last; k_q <= n_last; end
			ST_CHK_MID:
				if (cz_q < rz) begin
					hi_q <= mid;
					if (mid - lo_q <= NW'(1)) k_q <= mid;
				end else begin
					lo_q <= mid;
					if (hi_q - mid <= NW'(1)) k_q <= hi_q;
				end
			ST_DN_WAIT:
				if (pr.valid) begin
					if (pr.close) st_q <= STATUS_CLOSE;
					else if (pr.stop || k_q == '0) k_q <= hi_q;
					else k_q <= k_q - NW'(1);
				end
			ST_UP_WAIT:
				if (pr.valid) begin
					if (pr.close) st_q <= STATUS_CLOSE;
					else if (pr.stop || k_q + NW'(1) >= n_q) k_q <= n_q;
					else k_q <= k_q + NW'(1);
				end
			ST_SH_WR: k_q <= k_q - NW'(1);
			default: ;
		endcase
		if (state_q == ST_INS) pos_q <= hi_q;
		if (state_q == ST_IDLE) pos_q <= '0;
	end

	// handshake and result
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = (state_q == ST_OUT);
	assign status          = st_q;
	assign insert_position = (st_q == STATUS_OK) ? CNT_W'(pos_q) : '0;
	assign point_count     = CNT_W'(n_q);
	assign done_res        = (CNT_W+1)'(CNT_W'(n_q)) >= (CNT_W+1)'(target_q);

	// checks
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(POINT_CAPACITY)) else $error("count above capacity");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && st_q == STATUS_FULL |-> n_q == NW'(POINT_CAPACITY))
		else $error("full status with room");
	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !wr_en) else $error("table write while idle");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_INS) && $past(arst_n) |-> n_q == $past(n_q) + NW'(1))
		else $error("count did not grow on insert");

endmodule
